// ===== rtl/core/ring_order_walk_checker_unit_macros.svh =====
// assertion macros used by the ring order walk checker assertion file
`ifndef RING_ORDER_WALK_CHECKER_UNIT_MACROS_SVH
`define RING_ORDER_WALK_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ROWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define ROWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rowc_pkg.sv =====
// types, constants and codes of the ring order walk checker
`timescale 1ns / 1ps

package rowc_pkg;

  localparam int MAX_RANKS_DEF    = 32;
  localparam int MAX_CHANNELS_DEF = 8;

  // fixed field widths
  localparam int CHAN_W  = 3;
  localparam int RANK_W  = 5;
  localparam int COUNT_W = 6;
  localparam int MAP_W   = 32;

  localparam logic [COUNT_W-1:0] RANK_COUNT_RST = 6'd32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WALK = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_LOOP  = 2'd1,
    STAT_MISSING  = 2'd2,
    STAT_BAD_RANK = 2'd3
  } rowc_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } rowc_state_t;

endpackage

// ===== rtl/core/rowc_in_if.sv =====
// request channel: successor loads and walk requests
`timescale 1ns / 1ps

interface rowc_in_if import rowc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAN_W-1:0] channel;
  logic [RANK_W-1:0] entry_index;
  logic [RANK_W-1:0] successor_rank;
  logic [RANK_W-1:0] start_rank;

  modport source (output valid, op, channel, entry_index, successor_rank, start_rank,
                  input ready);
  modport sink (input valid, op, channel, entry_index, successor_rank, start_rank,
                output ready);
endinterface

// ===== rtl/core/rowc_out_if.sv =====
// result channel: one beat per walk step
`timescale 1ns / 1ps

interface rowc_out_if import rowc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] position;
  logic [RANK_W-1:0] ring_rank;
  logic              last;
  logic [1:0]        status;

  modport source (output valid, position, ring_rank, last, status, input ready);
  modport sink (input valid, position, ring_rank, last, status, output ready);
endinterface

// ===== rtl/core/ring_order_walk_checker_unit.sv =====
// ring order walk checker: successor memory, walk sequencer and result register
// a walk request loads the walk state; its first result beat then enters the result register
// throughput: one result beat per cycle while beats are taken; no request is taken during a walk
// the loop is one successor memory read per step, the read data registered in the memory
// a load writes the successor memory and gives no result
// reset (rst_n low, synchronous): idle, no result pending, rank_count 32; table undefined
`timescale 1ns / 1ps

module ring_order_walk_checker_unit import rowc_pkg::*; #(
  parameter int MAX_RANKS    = MAX_RANKS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rowc_in_if.sink            in_chan,
  rowc_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  // table geometry
  localparam int TABLE_DEPTH = MAX_CHANNELS * MAX_RANKS;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RANK_CAP    = (MAX_RANKS < MAP_W) ? MAX_RANKS : MAP_W;

  localparam logic [ADDR_W-1:0]  RANKS_A    = ADDR_W'(MAX_RANKS);
  localparam logic [COUNT_W:0]   MAX_RANKS_W = (COUNT_W + 1)'(MAX_RANKS);
  localparam logic [COUNT_W-1:0] CAP_W      = COUNT_W'(RANK_CAP);

  // channel number folded onto the channels that exist
  function automatic logic [CH_W-1:0] wrap_chan(input logic [CHAN_W-1:0] c);
    logic [CH_W-1:0] r;
    r = '0;
    for (int v = 0; v < (1 << CHAN_W); v++) begin
      if (c == CHAN_W'(v)) r = CH_W'(v % MAX_CHANNELS);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CH_W-1:0] c,
                                                 input logic [RANK_W-1:0] rk);
    return ADDR_W'(ADDR_W'(c) * RANKS_A) + ADDR_W'(rk);
  endfunction

  // successor memory, one entry per channel and rank
  logic [RANK_W-1:0] succ_mem [TABLE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [RANK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      succ_mem[wr_addr] <= in_chan.successor_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= succ_mem[rd_addr];
    end
  end

  // rank count register and its clamped value
  logic [COUNT_W-1:0] rank_count_r;
  logic [COUNT_W-1:0] eff_n;
  logic [MAP_W-1:0]   full_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r <= RANK_COUNT_RST;
    end else if (cfg_we) begin
      rank_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (rank_count_r == '0) begin
      eff_n = COUNT_W'(1);
    end else if (rank_count_r > CAP_W) begin
      eff_n = CAP_W;
    end else begin
      eff_n = rank_count_r;
    end
    if (eff_n >= COUNT_W'(MAP_W)) begin
      full_mask = '1;
    end else begin
      full_mask = (MAP_W'(1) << eff_n) - MAP_W'(1);
    end
  end

  // walk state
  rowc_state_t       state_r, state_nxt;
  logic [MAP_W-1:0]  vis_r, vis_nxt;
  logic [RANK_W-1:0] cur_r, cur_nxt;
  logic [RANK_W-1:0] step_r, step_nxt;
  logic              fault_r, fault_nxt;
  logic [RANK_W-1:0] start_r, start_nxt;
  logic [CH_W-1:0]   chan_r, chan_nxt;

  // result register
  logic              out_valid_r;
  logic [RANK_W-1:0] out_pos_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_last_r;
  rowc_status_t      out_status_r;

  logic              in_acc;
  logic              out_free;
  logic              fire;
  logic              start_ok;
  logic              entry_ok;
  logic [CH_W-1:0]   in_chan_w;

  // one step of the walk, from the successor just read
  logic              succ_ok;
  logic              fault_step;
  logic [RANK_W-1:0] cur_step;
  logic [MAP_W-1:0]  vis_step;
  logic              is_last;
  rowc_status_t      stat_step;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_chan_w = wrap_chan(in_chan.channel);
  assign start_ok  = {1'b0, in_chan.start_rank} < eff_n;
  assign entry_ok  = {2'b00, in_chan.entry_index} < MAX_RANKS_W;
  assign wr_addr   = tbl_addr(in_chan_w, in_chan.entry_index);

  always_comb begin
    succ_ok    = {1'b0, rdata_r} < eff_n;
    fault_step = fault_r || !succ_ok;
    cur_step   = fault_step ? cur_r : rdata_r;
    vis_step   = fault_r ? vis_r : (vis_r | (MAP_W'(1) << cur_r));
    is_last    = step_r == RANK_W'(eff_n - COUNT_W'(1));
    // bad rank wins over no loop back, which wins over a missing rank
    if (fault_step) begin
      stat_step = STAT_BAD_RANK;
    end else if (cur_step != start_r) begin
      stat_step = STAT_NO_LOOP;
    end else if ((vis_step & full_mask) != full_mask) begin
      stat_step = STAT_MISSING;
    end else begin
      stat_step = STAT_OK;
    end
  end

  // sequencer: idle takes requests, step emits one beat per walk step
  always_comb begin
    state_nxt     = state_r;
    vis_nxt       = vis_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    fault_nxt     = fault_r;
    start_nxt     = start_r;
    chan_nxt      = chan_r;
    in_chan.ready = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = tbl_addr(chan_r, cur_step);
    fire          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_acc) begin
          if (in_chan.op == OP_WALK) begin
            state_nxt = ST_STEP;
            vis_nxt   = '0;
            cur_nxt   = in_chan.start_rank;
            start_nxt = in_chan.start_rank;
            chan_nxt  = in_chan_w;
            step_nxt  = '0;
            // start beyond the ring is flagged at once, nothing is read
            fault_nxt = !start_ok;
            rd_en     = start_ok;
            rd_addr   = tbl_addr(in_chan_w, in_chan.start_rank);
          end else begin
            mem_we = entry_ok;
          end
        end
      end
      ST_STEP: begin
        if (out_free) begin
          fire      = 1'b1;
          vis_nxt   = vis_step;
          cur_nxt   = cur_step;
          fault_nxt = fault_step;
          step_nxt  = step_r + RANK_W'(1);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            // fetch the next successor; a stopped walk reads nothing more
            rd_en = !fault_step;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vis_r   <= '0;
      cur_r   <= '0;
      step_r  <= '0;
      fault_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vis_r   <= vis_nxt;
      cur_r   <= cur_nxt;
      step_r  <= step_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    chan_r  <= chan_nxt;
  end

  // result register: refilled in the cycle its beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pos_r    <= step_r;
      out_rank_r   <= cur_r;
      out_last_r   <= is_last;
      out_status_r <= is_last ? stat_step : STAT_OK;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.position  = out_pos_r;
  assign out_chan.ring_rank = out_rank_r;
  assign out_chan.last      = out_last_r;
  assign out_chan.status    = out_status_r;

endmodule

// ===== rtl/core/rowc_checker.sv =====
// port-level assertions of the ring order walk checker and their bind
`timescale 1ns / 1ps
`include "ring_order_walk_checker_unit_macros.svh"

module rowc_checker import rowc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [RANK_W-1:0] out_position,
  input logic [RANK_W-1:0] out_ring_rank,
  input logic              out_last,
  input logic [1:0]        out_status
);

  // a stalled result beat holds its payload
  `ROWC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_position) && $stable(out_ring_rank) && $stable(out_last) && $stable(out_status), "result beat changed while stalled")

  // a walk request closes the request side in the next cycle
  `ROWC_ASSERT_NEXT(a_walk_busy, clk, rst_n, in_valid && in_ready && (in_op == OP_WALK), !in_ready, "request taken while a walk starts")

  // no request is taken while a walk still has beats to give
  `ROWC_ASSERT_NOW(a_mid_walk, clk, rst_n, out_valid && !out_last, !in_ready, "request side open in the middle of a walk")

  // a walk's beats follow one another with rising positions
  `ROWC_ASSERT_NEXT(a_pos_step, clk, rst_n, out_valid && out_ready && !out_last, out_valid && (out_position == $past(out_position) + 5'd1), "walk beat missing or out of order")

  // status is only carried on the last beat
  `ROWC_ASSERT_NOW(a_status_last, clk, rst_n, out_valid && !out_last, out_status == STAT_OK, "status set before the last beat")

endmodule

bind ring_order_walk_checker_unit rowc_checker u_rowc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_op        (in_chan.op),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_position (out_chan.position),
  .out_ring_rank(out_chan.ring_rank),
  .out_last     (out_chan.last),
  .out_status   (out_chan.status)
);
